>>> sv/sfp_pkg.sv
// sfp_pkg: shared constants and result type for the sync frame parser
// no dependencies
package sfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 5;
	localparam int unsigned NUM_POS_BYTES = 4;
	localparam int unsigned NUM_HEIGHT_BYTES = 2;
	localparam int unsigned NUM_CMD_BYTES = 9;

	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
	localparam logic [POS_W-1:0] PAYLOAD_FIRST = 5'd2;
	localparam logic [POS_W-1:0] HEIGHT_FIRST = 5'd6;
	localparam logic [POS_W-1:0] CMD_FIRST = 5'd8;
	localparam logic [POS_W-1:0] CHECK_POS = 5'd17;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic checksum_ok;
		logic [31:0] position_data;
		logic [15:0] height_data;
		logic [63:0] command_low;
		logic [7:0] command_high;
	} result_t;

endpackage

>>> sv/sfp_parse.sv
// sfp_parse: frame position counter, running sum and payload capture
// depends on sfp_pkg
module sfp_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  sfp_pkg::byte_t rx_byte,
	input  sfp_pkg::byte_t sync_byte,
	output logic           emit,
	output sfp_pkg::result_t result
);
	import sfp_pkg::*;

	pos_t  pos_q;
	byte_t sum_q;
	logic [31:0] pos_store_q;
	logic [15:0] height_q;
	byte_t cmd_q [NUM_CMD_BYTES];

	logic hunting;
	logic in_payload;
	byte_t sum_next;

	assign hunting = (pos_q < PAYLOAD_FIRST);
	assign in_payload = !hunting && (pos_q < CHECK_POS);
	assign emit = (pos_q == CHECK_POS);
	assign sum_next = 8'(sum_q + rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			pos_store_q <= '0;
			height_q <= '0;
			for (int i = 0; i < NUM_CMD_BYTES; i++) begin
				cmd_q[i] <= '0;
			end
		end else if (step) begin
			if (hunting) begin
				// non-sync bytes are dropped while hunting
				if (rx_byte == sync_byte) begin
					sum_q <= sum_next;
					pos_q <= 5'(pos_q + 5'd1);
				end
			end else if (in_payload) begin
				sum_q <= sum_next;
				pos_q <= 5'(pos_q + 5'd1);
				for (int i = 0; i < NUM_POS_BYTES; i++) begin
					if (pos_q == 5'(PAYLOAD_FIRST + i)) pos_store_q[8*i +: 8] <= rx_byte;
				end
				for (int i = 0; i < NUM_HEIGHT_BYTES; i++) begin
					if (pos_q == 5'(HEIGHT_FIRST + i)) height_q[8*i +: 8] <= rx_byte;
				end
				for (int i = 0; i < NUM_CMD_BYTES; i++) begin
					if (pos_q == 5'(CMD_FIRST + i)) cmd_q[i] <= rx_byte;
				end
			end else begin
				// checksum byte, or an unreachable position: restart the frame
				sum_q <= '0;
				pos_q <= '0;
			end
		end
	end

	always_comb begin
		result.checksum_ok = (rx_byte == sum_q);
		result.position_data = pos_store_q;
		result.height_data = height_q;
		for (int i = 0; i < 8; i++) begin
			result.command_low[8*i +: 8] = cmd_q[i];
		end
		result.command_high = cmd_q[NUM_CMD_BYTES-1];
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CHECK_POS)
		else $error("frame position beyond checksum slot");

	a_sum_clear_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> sum_q == '0)
		else $error("running sum not clear at frame start");

	a_restart_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> pos_q == '0 && sum_q == '0)
		else $error("frame not restarted after checksum word");

	a_payload_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_payload |=> pos_q == 5'($past(pos_q) + 5'd1))
		else $error("position did not advance on payload word");

endmodule

>>> sv/sync_frame_parser_with_sum_check.sv
// a checksum word passes the input register, then the result register, before out_valid shows its result
// throughput: one word per cycle while in_stall is low; only a counter step and an 8-bit add per word
// the input register stalls only when a result is ready and the output register is held
// reset (arst_n low) clears position, sum, captures and valids; sync_byte returns to 0xAA
// top level: input register, sfp_parse, result register
// depends on sfp_pkg, sfp_parse
module sync_frame_parser_with_sum_check (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        checksum_ok,
	output logic [31:0] position_data,
	output logic [15:0] height_data,
	output logic [63:0] command_low,
	output logic [7:0]  command_high
);
	import sfp_pkg::*;

	// sync pattern register
	byte_t sync_byte_q;

	// input stage
	logic  valid_s1;
	byte_t rx_byte_s1;

	// result stage
	logic    out_valid_q;
	result_t result_q;

	// parser hookup
	logic    step;
	logic    emit;
	result_t result;
	logic    out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_byte_q <= cfg_wdata;
		end
	end

	// result register can take a new word when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	// a word in the input stage moves on unless it produces a result that has nowhere to go
	assign step = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	sfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_byte_s1),
		.sync_byte (sync_byte_q),
		.emit      (emit),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum_ok = result_q.checksum_ok;
	assign position_data = result_q.position_data;
	assign height_data = result_q.height_data;
	assign command_low = result_q.command_low;
	assign command_high = result_q.command_high;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(step && emit))
		else $error("held result overwritten");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && emit)
		else $error("input stalled without a pending result word");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> out_valid_q)
		else $error("result word lost after checksum");

endmodule
